FILE: design/pl0_pkg.sv
// pl0_pkg: shared types and constants for the pl0 stack machine
// depends on nothing
`default_nettype none
package pl0_pkg;
	typedef enum logic [3:0] {
		OP_LIT = 4'd0, OP_OPR = 4'd1, OP_LOD = 4'd2, OP_STO = 4'd3, OP_CAL = 4'd4,
		OP_INT = 4'd5, OP_JMP = 4'd6, OP_JPC = 4'd7, OP_RED = 4'd8, OP_WRT = 4'd9
	} opcode_t;
	localparam logic [10:0] OPR_RET = 11'd0;
	localparam logic [10:0] OPR_NEG = 11'd1;
	localparam logic [10:0] OPR_ADD = 11'd2;
	localparam logic [10:0] OPR_SUB = 11'd3;
	localparam logic [10:0] OPR_MUL = 11'd4;
	localparam logic [10:0] OPR_DIV = 11'd5;
	localparam logic [10:0] OPR_ODD = 11'd6;
	localparam logic [10:0] OPR_EQ  = 11'd7;
	localparam logic [10:0] OPR_NE  = 11'd8;
	localparam logic [10:0] OPR_LT  = 11'd9;
	localparam logic [10:0] OPR_GE  = 11'd10;
	localparam logic [10:0] OPR_GT  = 11'd11;
	localparam logic [10:0] OPR_LE  = 11'd12;
	localparam logic [1:0] FLT_NONE = 2'd0;
	localparam logic [1:0] FLT_DIV0 = 2'd1;
	localparam logic [1:0] FLT_STACK = 2'd2;
	localparam logic [1:0] FLT_CODE = 2'd3;
endpackage
`default_nettype wire

FILE: design/pl0_ram.sv
// pl0_ram: generic single-port synchronous ram, registered read
// depends on nothing
`default_nettype none
module pl0_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  addr,
	input  wire [WIDTH-1:0]          wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: design/pl0_div.sv
// pl0_div: signed truncating divider, one quotient bit per cycle
// depends on pl0_pkg
`default_nettype none
module pl0_div import pl0_pkg::*; #(
	parameter int W = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start,
	input  wire  [W-1:0] x,
	input  wire  [W-1:0] y,
	output logic         busy,
	output logic [W-1:0] quot
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] rem_q, q_q, d_q;
	logic [CW-1:0] cnt_q;
	logic neg_q;
	logic [W:0] trial;
	logic [W-1:0] ax, ay;
	assign ax = x[W-1] ? (~x + 1'b1) : x;
	assign ay = y[W-1] ? (~y + 1'b1) : y;
	assign trial = {rem_q, q_q[W-1]} - {1'b0, d_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q <= ax;
			d_q <= ay;
			neg_q <= x[W-1] ^ y[W-1];
		end else if (cnt_q != '0) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], q_q[W-1]};
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end
	assign busy = (cnt_q != '0) || start;
	assign quot = neg_q ? (~q_q + 1'b1) : q_q;
endmodule
`default_nettype wire

FILE: design/pl0_stack_machine.sv
// pl0_stack_machine: pl/0 p-code machine around one data stack ram
// depends on pl0_pkg, pl0_ram, pl0_div
//
// usage: the host fetches the instruction at next_pc (start at 0) and offers
//   it on the input channel (valid/stall) with read_value for red.
// one result item per instruction on the output channel: next_pc, done_res
//   (pc returned to zero), out_valid/out_value for wrt, and fault.
// timing is set by the single ram port: a read takes an address step, then
//   a data step; a write is one access, and each static link costs one read.
// a divide waits in its own step until the shift divider is done; the result
//   item becomes valid as the machine returns to idle and can take the next item.
// one item is in work at a time; in_stall is high whenever the machine is
//   not idle. a finished result waits in the output register while the next
//   item is taken and executed; a receiver stall holds that result and the
//   machine then waits in its result step with the input stalled.
// on a fault no state changes and next_pc repeats the faulting pc.
// reset: top 0, base 1, pc 0; a clearing pass is not done, cells 1-3 are
//   written with zero in the init state after reset (input stalled then).
`default_nettype none
module pl0_stack_machine import pl0_pkg::*; #(
	parameter int STACK_DEPTH = 1024,
	parameter int CODE_SIZE = 1024,
	parameter int MAX_LEVEL = 3,
	parameter int DATA_WIDTH = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [3:0]         opcode,
	input  wire  [1:0]         level,
	input  wire  [10:0]        operand,
	input  wire  signed [31:0] read_value,
	output logic               res_valid,
	input  wire                res_stall,
	output logic [9:0]         next_pc,
	output logic               done_res,
	output logic               out_valid,
	output logic signed [31:0] out_value,
	output logic [1:0]         fault
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int PW = $clog2(CODE_SIZE);
	localparam int DW = DATA_WIDTH;
	// wide enough for address plus operand sums without wrap
	localparam int EW = ((AW > 11) ? AW : 11) + 3;
	localparam logic [EW-1:0] SDEP = EW'(STACK_DEPTH);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_LINK, S_RD1, S_RD2, S_EXEC, S_DIV, S_WR1, S_WR2, S_WR3, S_RES
	} state_t;
	state_t state_q;

	logic [AW-1:0] top_q, base_q;
	logic [PW-1:0] pc_q;
	logic [1:0] init_q;
	logic [3:0] op_q;
	logic [1:0] lcnt_q;
	logic [10:0] a_q;
	logic [DW-1:0] rv_q, x_q, y_q, wd1_q;
	logic [EW-1:0] link_q; // current walked base
	logic [AW-1:0] ea_q;
	logic rd_pend_q;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [DW-1:0] ram_wd, ram_rd;
	pl0_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
	);

	logic div_go_q;
	logic div_busy;
	logic [DW-1:0] dquot;
	pl0_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .x(x_q), .y(y_q),
		.busy(div_busy), .quot(dquot)
	);

	logic [EW-1:0] t_e, b_e, a_e;
	assign t_e = EW'(top_q);
	assign b_e = EW'(base_q);
	assign a_e = EW'(a_q);

	// ram port: one access per cycle
	always_comb begin
		ram_we = 1'b0;
		ram_addr = '0;
		ram_wd = '0;
		unique case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
				ram_addr = AW'(init_q + 2'd1);
			end
			S_LINK: ram_addr = link_q[AW-1:0];
			S_RD1: ram_addr = (op_q == OP_OPR && a_q == OPR_RET) ? AW'(b_e + 1)
				: (op_q == OP_LOD) ? ea_q : top_q;
			S_RD2: ram_addr = (op_q == OP_OPR && a_q == OPR_RET) ? AW'(b_e + 2)
				: AW'(t_e - 1);
			S_WR1, S_WR2, S_WR3: begin
				ram_we = 1'b1;
				ram_addr = ea_q;
				ram_wd = wd1_q;
			end
			default: ;
		endcase
	end

	// result fields
	logic [PW-1:0] npc_q;
	logic [1:0] flt_q;
	logic ov_q;
	logic [DW-1:0] ovl_q;

	logic [PW-1:0] pc_inc;
	assign pc_inc = pc_q + 1'b1;

	function automatic logic lts(input logic [DW-1:0] p, input logic [DW-1:0] r);
		lts = $signed(p) < $signed(r);
	endfunction

	// commit helper values
	logic [DW-1:0] mul_r;
	assign mul_r = x_q * y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			top_q <= '0;
			base_q <= AW'(1);
			pc_q <= '0;
			res_valid <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			// rd_pend_q marks a read state's data step, when the registered ram read has returned
			rd_pend_q <= ((state_q == S_LINK || state_q == S_RD1 || state_q == S_RD2)
				&& !rd_pend_q) || (state_q == S_DIV);
			if (res_valid && !res_stall && state_q != S_RES) res_valid <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + 2'd1;
					if (init_q == 2'd2) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) begin
					op_q <= opcode;
					lcnt_q <= level;
					a_q <= operand;
					rv_q <= DW'(read_value);
					link_q <= b_e;
					npc_q <= pc_q;
					flt_q <= FLT_NONE;
					ov_q <= 1'b0;
					ovl_q <= '0;
					if (32'(level) > MAX_LEVEL || opcode > OP_WRT
						|| (opcode == OP_OPR && operand > OPR_LE)) begin
						flt_q <= FLT_CODE;
						state_q <= S_RES;
					end else if (opcode == OP_STO && top_q == '0) begin
						// store needs a value on the stack
						flt_q <= FLT_STACK;
						state_q <= S_RES;
					end else if ((opcode == OP_LOD || opcode == OP_STO
						|| opcode == OP_CAL || opcode == OP_RED) && level != 2'd0) begin
						state_q <= S_LINK;
					end else begin
						state_q <= S_EXEC;
						ea_q <= AW'(b_e + ((opcode == OP_CAL) ? '0 : EW'(operand)));
						if ((opcode == OP_LOD || opcode == OP_STO || opcode == OP_RED)
							&& b_e + EW'(operand) >= SDEP) begin
							flt_q <= FLT_STACK;
							state_q <= S_RES;
						end else if (opcode == OP_LOD) state_q <= S_RD1;
						else if (opcode == OP_OPR && operand == OPR_RET) begin
							if (base_q == '0 || b_e + 2 >= SDEP) begin
								flt_q <= FLT_STACK;
								state_q <= S_RES;
							end else state_q <= S_RD1;
						end else if ((opcode == OP_OPR && operand != OPR_RET)
							|| opcode == OP_STO || opcode == OP_JPC || opcode == OP_WRT) begin
							if (top_q == '0) begin
								flt_q <= FLT_STACK;
								state_q <= S_RES;
							end else state_q <= S_RD1;
						end
					end
				end
				S_LINK: begin
					// read issued in the address step, data sampled in the data step (rd_pend_q)
					if (rd_pend_q) begin
						if (EW'(ram_rd) >= SDEP || ram_rd >= DW'(STACK_DEPTH)) begin
							flt_q <= FLT_STACK;
							state_q <= S_RES;
						end else begin
							link_q <= EW'(ram_rd[AW-1:0]);
							lcnt_q <= lcnt_q - 2'd1;
							if (lcnt_q == 2'd1) begin
								if (EW'(ram_rd[AW-1:0]) + ((op_q == OP_CAL) ? '0 : a_e) >= SDEP)
								begin
									flt_q <= FLT_STACK;
									state_q <= S_RES;
								end else begin
									ea_q <= AW'(EW'(ram_rd[AW-1:0])
										+ ((op_q == OP_CAL) ? '0 : a_e));
									state_q <= (op_q == OP_LOD || op_q == OP_STO) ? S_RD1
										: S_EXEC;
								end
							end
						end
					end
				end
				S_RD1: begin
					if (rd_pend_q) begin
						y_q <= ram_rd;
						if ((op_q == OP_OPR && a_q != OPR_NEG && a_q != OPR_ODD)
							|| (op_q == OP_OPR && a_q == OPR_RET)) begin
							if (op_q == OP_OPR && a_q != OPR_RET && top_q < AW'(2)) begin
								flt_q <= FLT_STACK;
								state_q <= S_RES;
							end else state_q <= S_RD2;
						end else state_q <= S_EXEC;
					end
				end
				S_RD2: begin
					if (rd_pend_q) begin
						x_q <= ram_rd;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RES;
					unique case (op_q)
						OP_LIT: if (t_e + 1 >= SDEP) flt_q <= FLT_STACK;
							else begin
								top_q <= top_q + 1'b1;
								ea_q <= top_q + 1'b1;
								wd1_q <= DW'(a_q);
								npc_q <= pc_inc;
								state_q <= S_WR1;
							end
						OP_LOD: if (t_e + 1 >= SDEP) flt_q <= FLT_STACK;
							else begin
								top_q <= top_q + 1'b1;
								ea_q <= top_q + 1'b1;
								wd1_q <= y_q;
								npc_q <= pc_inc;
								state_q <= S_WR1;
							end
						OP_STO: begin
							top_q <= top_q - 1'b1;
							wd1_q <= y_q;
							npc_q <= pc_inc;
							state_q <= S_WR1;
						end
						OP_RED: begin
							wd1_q <= rv_q;
							npc_q <= pc_inc;
							state_q <= S_WR1;
						end
						OP_INT: if (t_e + a_e >= SDEP) flt_q <= FLT_STACK;
							else begin
								top_q <= AW'(t_e + a_e);
								npc_q <= pc_inc;
							end
						OP_JMP: npc_q <= PW'(a_q);
						OP_JPC: begin
							top_q <= top_q - 1'b1;
							npc_q <= (y_q == '0) ? PW'(a_q) : pc_inc;
						end
						OP_WRT: begin
							top_q <= top_q - 1'b1;
							ov_q <= 1'b1;
							ovl_q <= y_q;
							npc_q <= pc_inc;
						end
						OP_CAL: if (t_e + 3 >= SDEP) flt_q <= FLT_STACK;
							else begin
								// three link cells: static link, dynamic link, return
								wd1_q <= DW'(link_q[AW-1:0]);
								ea_q <= top_q + 1'b1;
								x_q <= DW'(base_q);
								y_q <= DW'(pc_inc);
								base_q <= top_q + 1'b1;
								npc_q <= PW'(a_q);
								state_q <= S_WR1;
							end
						OP_OPR: begin
							if (a_q == OPR_RET) begin
								// y = saved base, x = return address
								if (y_q >= DW'(STACK_DEPTH)) flt_q <= FLT_STACK;
								else begin
									top_q <= base_q - 1'b1;
									base_q <= y_q[AW-1:0];
									npc_q <= x_q[PW-1:0];
								end
							end else if (a_q == OPR_NEG || a_q == OPR_ODD) begin
								ea_q <= top_q;
								wd1_q <= (a_q == OPR_NEG) ? (~y_q + 1'b1) : DW'(y_q[0]);
								npc_q <= pc_inc;
								state_q <= S_WR1;
							end else if (a_q == OPR_DIV) begin
								if (y_q == '0) flt_q <= FLT_DIV0;
								else state_q <= S_DIV;
							end else begin
								ea_q <= top_q - 1'b1;
								top_q <= top_q - 1'b1;
								npc_q <= pc_inc;
								state_q <= S_WR1;
								priority case (a_q)
									OPR_ADD: wd1_q <= x_q + y_q;
									OPR_SUB: wd1_q <= x_q - y_q;
									OPR_MUL: wd1_q <= mul_r;
									OPR_EQ: wd1_q <= DW'(x_q == y_q);
									OPR_NE: wd1_q <= DW'(x_q != y_q);
									OPR_LT: wd1_q <= DW'(lts(x_q, y_q));
									OPR_GE: wd1_q <= DW'(!lts(x_q, y_q));
									OPR_GT: wd1_q <= DW'(lts(y_q, x_q));
									default: wd1_q <= DW'(!lts(y_q, x_q));
								endcase
							end
						end
						default: flt_q <= FLT_CODE;
					endcase
				end
				S_DIV: if (!div_busy && rd_pend_q) begin
						ea_q <= top_q - 1'b1;
						top_q <= top_q - 1'b1;
						wd1_q <= dquot;
						npc_q <= pc_inc;
						state_q <= S_WR1;
					end
				S_WR1: begin
					if (op_q == OP_CAL) begin
						ea_q <= ea_q + 1'b1;
						wd1_q <= x_q;
						state_q <= S_WR2;
					end else state_q <= S_RES;
				end
				S_WR2: begin
					ea_q <= ea_q + 1'b1;
					wd1_q <= y_q;
					state_q <= S_WR3;
				end
				S_WR3: state_q <= S_RES;
				S_RES: if (!res_valid || !res_stall) begin
					res_valid <= 1'b1;
					next_pc <= 10'(npc_q);
					done_res <= (flt_q == FLT_NONE) && (npc_q == '0);
					fault <= flt_q;
					out_valid <= ov_q;
					out_value <= 32'(ovl_q);
					if (flt_q == FLT_NONE) pc_q <= npc_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the divider is started on entry to S_DIV
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_go_q <= 1'b0;
		else div_go_q <= (state_q == S_EXEC) && (op_q == OP_OPR) && (a_q == OPR_DIV)
			&& (y_q != '0);
	end

	assign in_stall = (state_q != S_IDLE);

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("accept while busy");
	a_fault_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && fault != FLT_NONE) |-> !out_valid) else $error("write on fault");
	a_done_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && done_res) |-> (next_pc == '0)) else $error("done with pc");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		($past(res_valid) && $past(res_stall)) |-> res_valid) else $error("result lost");
`endif
endmodule
`default_nettype wire

FILE: tb/pl0_stack_machine_tb.sv
// pl0_stack_machine_tb: self-checking testbench for the pl/0 p-code stack machine
// depends on pl0_pkg and pl0_stack_machine; generates programs, predicts every result item
`default_nettype none
module pl0_stack_machine_tb;
	import pl0_pkg::*;

	localparam int DEPTH = 1024;
	localparam int CODE = 1024;
	localparam logic [3:0] OP_BAD = 4'd12;
	localparam logic [3:0] OP_TOP = 4'd15;

	typedef struct packed {
		logic [3:0]  op;
		logic [1:0]  lev;
		logic [10:0] arg;
		logic [31:0] rv;
		logic        hold;   // sender waits until nothing is outstanding
	} instr_t;

	typedef struct packed {
		logic [9:0]  pc;
		logic        done;
		logic        ov;
		logic [31:0] val;
		logic [1:0]  flt;
	} pc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] opcode = '0;
	logic [1:0] level = '0;
	logic [10:0] operand = '0;
	logic signed [31:0] read_value = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [9:0] next_pc;
	logic done_res;
	logic out_valid;
	logic signed [31:0] out_value;
	logic [1:0] fault;

	pl0_stack_machine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .level(level), .operand(operand), .read_value(read_value),
		.res_valid(res_valid), .res_stall(res_stall),
		.next_pc(next_pc), .done_res(done_res), .out_valid(out_valid),
		.out_value(out_value), .fault(fault)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// machine state as the predictor sees it
	logic [31:0] cells [DEPTH];
	bit cell_set [DEPTH];
	int unsigned sp_top, fr_base, pc_reg;
	bit stray_read;   // an instruction touched a cell never written
	bit commit_en;    // low for a trial run that must leave the state alone

	instr_t pending_items[$];
	pc_result_t pending_res[$];
	pc_result_t expected_results[$];
	bit gen_done = 0;
	bit failed = 0;
	int cyc = 0;
	int results_seen = 0;
	bit in_taken = 0;

	function automatic logic [31:0] cell_rd(int unsigned a);
		if (!cell_set[a]) stray_read = 1;
		return cell_set[a] ? cells[a] : 32'd0;
	endfunction

	function automatic void cell_wr(int unsigned a, logic [31:0] v);
		if (commit_en) begin
			cells[a] = v;
			cell_set[a] = 1;
		end
	endfunction

	// walk the static links, then add the frame offset
	function automatic bit link_addr(int unsigned lev, int unsigned off,
			output int unsigned addr);
		longint unsigned b1;
		int k;
		b1 = fr_base;
		addr = 0;
		for (k = 0; k < lev; k++) begin
			if (b1 >= DEPTH) return 0;
			b1 = cell_rd(b1);
			if (b1 >= DEPTH) return 0;
		end
		if (b1 + off >= DEPTH) return 0;
		addr = b1 + off;
		return 1;
	endfunction

	// executes one instruction; returns the fault code, state kept on a fault
	function automatic logic [1:0] pcode_exec(instr_t it, output logic [31:0] outv,
			output bit ov);
		int unsigned t, b, nxt, addr, a;
		longint unsigned sl;
		logic [31:0] x, y, r;
		t = sp_top;
		b = fr_base;
		nxt = (pc_reg + 1) % CODE;
		a = it.arg;
		outv = '0;
		ov = 0;
		r = '0;
		case (it.op)
			OP_LIT: begin
				if (t + 1 >= DEPTH) return FLT_STACK;
				t++;
				cell_wr(t, a);
			end
			OP_OPR: begin
				if (a == OPR_RET) begin
					if (b == 0 || b + 2 >= DEPTH) return FLT_STACK;
					sl = cell_rd(b + 1);
					if (sl >= DEPTH) return FLT_STACK;
					t = b - 1;
					nxt = cell_rd(b + 2) % CODE;
					b = sl;
				end else if (a == OPR_NEG || a == OPR_ODD) begin
					if (t < 1) return FLT_STACK;
					x = cell_rd(t);
					cell_wr(t, (a == OPR_NEG) ? -x : {31'd0, x[0]});
				end else begin
					if (a > OPR_LE) return FLT_CODE;
					if (t < 2) return FLT_STACK;
					x = cell_rd(t - 1);
					y = cell_rd(t);
					case (a)
						OPR_ADD: r = x + y;
						OPR_SUB: r = x - y;
						OPR_MUL: r = x * y;
						OPR_DIV: begin
							if (y == 0) return FLT_DIV0;
							// most negative over minus one wraps to itself
							if (x == 32'h8000_0000 && y == 32'hffff_ffff) r = x;
							else r = $signed(x) / $signed(y);
						end
						OPR_EQ: r = {31'd0, x == y};
						OPR_NE: r = {31'd0, x != y};
						OPR_LT: r = {31'd0, $signed(x) < $signed(y)};
						OPR_GE: r = {31'd0, $signed(x) >= $signed(y)};
						OPR_GT: r = {31'd0, $signed(x) > $signed(y)};
						default: r = {31'd0, $signed(x) <= $signed(y)};
					endcase
					t--;
					cell_wr(t, r);
				end
			end
			OP_LOD: begin
				if (!link_addr(it.lev, a, addr)) return FLT_STACK;
				if (t + 1 >= DEPTH) return FLT_STACK;
				x = cell_rd(addr);
				t++;
				cell_wr(t, x);
			end
			OP_STO: begin
				if (!link_addr(it.lev, a, addr)) return FLT_STACK;
				if (t < 1) return FLT_STACK;
				cell_wr(addr, cell_rd(t));
				t--;
			end
			OP_CAL: begin
				if (!link_addr(it.lev, 0, addr)) return FLT_STACK;
				if (t + 3 >= DEPTH) return FLT_STACK;
				cell_wr(t + 1, addr);
				cell_wr(t + 2, b);
				cell_wr(t + 3, nxt);
				b = t + 1;
				nxt = a % CODE;
			end
			OP_INT: begin
				if (t + a >= DEPTH) return FLT_STACK;
				t += a;
			end
			OP_JMP: nxt = a % CODE;
			OP_JPC: begin
				if (t < 1) return FLT_STACK;
				if (cell_rd(t) == 0) nxt = a % CODE;
				t--;
			end
			OP_RED: begin
				if (!link_addr(it.lev, a, addr)) return FLT_STACK;
				cell_wr(addr, it.rv);
			end
			OP_WRT: begin
				if (t < 1) return FLT_STACK;
				outv = cell_rd(t);
				ov = 1;
				t--;
			end
			default: return FLT_CODE;
		endcase
		if (commit_en) begin
			sp_top = t;
			fr_base = b;
			pc_reg = nxt;
		end
		return FLT_NONE;
	endfunction

	// queues the item with its result unless it would read an unwritten cell
	function automatic bit queue_instr(instr_t it);
		pc_result_t res;
		logic [31:0] v;
		bit ov;
		logic [1:0] f;
		stray_read = 0;
		commit_en = 0;
		void'(pcode_exec(it, v, ov));
		commit_en = 1;
		if (stray_read) return 0;
		f = pcode_exec(it, v, ov);
		res.pc = pc_reg[9:0];
		res.done = (f == FLT_NONE && pc_reg == 0);
		res.ov = (f == FLT_NONE) && ov;
		res.val = (f == FLT_NONE) ? v : 32'd0;
		res.flt = f;
		pending_items.push_back(it);
		pending_res.push_back(res);
		return 1;
	endfunction

	function automatic instr_t mk(logic [3:0] op, logic [1:0] lev, logic [10:0] arg,
			logic [31:0] rv);
		instr_t it;
		it.op = op;
		it.lev = lev;
		it.arg = arg;
		it.rv = rv;
		it.hold = 0;
		return it;
	endfunction

	// mostly well-formed instructions with small offsets, some noise
	function automatic instr_t rand_instr();
		int w;
		logic [1:0] lev;
		logic [10:0] off;
		logic [31:0] rv;
		w = $urandom_range(0, 99);
		lev = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'd0;
		off = ($urandom_range(0, 15) == 0) ? 11'($urandom) : 11'($urandom_range(0, 6));
		rv = $urandom;
		if (w < 20)
			return mk(OP_LIT, lev, ($urandom_range(0, 3) == 0) ? 11'($urandom)
				: 11'($urandom_range(0, 9)), rv);
		else if (w < 45)
			return mk(OP_OPR, lev, ($urandom_range(0, 19) == 0) ? 11'($urandom)
				: 11'($urandom_range(0, 12)), rv);
		else if (w < 57) return mk(OP_LOD, lev, off, rv);
		else if (w < 65) return mk(OP_STO, lev, off, rv);
		else if (w < 70) return mk(OP_CAL, lev, 11'($urandom), rv);
		else if (w < 75)
			return mk(OP_INT, lev, ($urandom_range(0, 15) == 0) ? 11'($urandom)
				: 11'($urandom_range(0, 4)), rv);
		else if (w < 78) return mk(OP_JMP, lev, 11'($urandom), rv);
		else if (w < 83) return mk(OP_JPC, lev, 11'($urandom), rv);
		else if (w < 89) return mk(OP_RED, lev, off, rv);
		else if (w < 97) return mk(OP_WRT, lev, off, rv);
		return mk(4'($urandom_range(OP_BAD - 2, OP_TOP)), lev, off, rv);
	endfunction

	// stimulus: directed corner cases, then random programs
	initial begin
		instr_t it;
		int n, tries;
		for (n = 0; n < DEPTH; n++) begin
			cells[n] = '0;
			cell_set[n] = (n >= 1 && n <= 3);
		end
		sp_top = 0;
		fr_base = 1;
		pc_reg = 0;
		commit_en = 1;
		// underflow on an empty stack, unknown codes
		void'(queue_instr(mk(OP_WRT, 0, 0, 0)));
		void'(queue_instr(mk(OP_OPR, 0, OPR_ADD, 0)));
		void'(queue_instr(mk(OP_BAD, 0, 0, 0)));
		void'(queue_instr(mk(OP_OPR, 0, OPR_LE + 1, 0)));
		void'(queue_instr(mk(OP_LIT, 0, 11'h7ff, 0)));
		void'(queue_instr(mk(OP_LIT, 0, 0, 0)));
		// divide by zero leaves the stack alone
		void'(queue_instr(mk(OP_OPR, 0, OPR_DIV, 0)));
		// most negative divided by minus one
		void'(queue_instr(mk(OP_RED, 0, 1, 32'h8000_0000)));
		void'(queue_instr(mk(OP_LOD, 0, 1, 0)));
		void'(queue_instr(mk(OP_LIT, 0, 1, 0)));
		void'(queue_instr(mk(OP_OPR, 0, OPR_NEG, 0)));
		void'(queue_instr(mk(OP_OPR, 0, OPR_DIV, 0)));
		void'(queue_instr(mk(OP_WRT, 0, 0, 0)));
		// stack overflow
		void'(queue_instr(mk(OP_INT, 0, 11'h7ff, 0)));
		// call, deep links, return, done
		void'(queue_instr(mk(OP_CAL, 0, 5, 0)));
		void'(queue_instr(mk(OP_LOD, 1, 1, 0)));
		void'(queue_instr(mk(OP_LOD, 3, 0, 0)));
		void'(queue_instr(mk(OP_OPR, 0, OPR_RET, 0)));
		void'(queue_instr(mk(OP_JMP, 0, 0, 0)));
		void'(queue_instr(mk(OP_LIT, 0, 7, 0)));
		void'(queue_instr(mk(OP_OPR, 0, OPR_ODD, 0)));
		void'(queue_instr(mk(OP_JPC, 0, 3, 0)));
		void'(queue_instr(mk(OP_RED, 3, 11'h7ff, 32'h7fff_ffff)));
		for (n = 0; n < 400; n++) begin
			tries = 0;
			it = rand_instr();
			it.hold = (n == 200);
			while (!queue_instr(it)) begin
				tries++;
				it = (tries > 30) ? mk(OP_LIT, 0, 11'($urandom), $urandom) : rand_instr();
				it.hold = (n == 200);
			end
		end
		gen_done = 1;
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) cyc <= cyc + 1;

	// input acceptance: the result of this item becomes expected
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall) expected_results.push_back(pending_res.pop_front());
	end

	// sender: no gaps while cyc is between 3000 and 4500, random gaps otherwise
	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
			in_valid <= 1'b1;
		end else if (arst_n && gen_done && pending_items.size() != 0
				&& !(pending_items[0].hold && expected_results.size() != 0)
				&& ((cyc > 3000 && cyc < 4500) || $urandom_range(0, 99) >= 8)) begin
			instr_t it;
			it = pending_items.pop_front();
			opcode <= it.op;
			level <= it.lev;
			operand <= it.arg;
			read_value <= it.rv;
			in_valid <= 1'b1;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: random stalls plus one long hold-off so the block backs up
	int long_hold = 0;
	bit long_done = 0;
	always @(negedge clk) begin
		if (long_hold > 0) begin
			long_hold <= long_hold - 1;
			res_stall <= 1'b1;
		end else if (!long_done && results_seen >= 120) begin
			long_done <= 1;
			long_hold <= 300;
			res_stall <= 1'b1;
		end else begin
			res_stall <= !(cyc > 3000 && cyc < 4500) && ($urandom_range(0, 99) < 8);
		end
	end

	// result checking against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			pc_result_t e;
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				$display("%0t: result item with nothing expected, pc %0d", $time, next_pc);
				failed = 1;
			end else begin
				e = expected_results.pop_front();
				if (next_pc !== e.pc) begin
					$display("%0t: next_pc expected %0d actual %0d", $time, e.pc, next_pc);
					failed = 1;
				end
				if (done_res !== e.done) begin
					$display("%0t: done_res expected %0d actual %0d", $time, e.done, done_res);
					failed = 1;
				end
				if (out_valid !== e.ov) begin
					$display("%0t: out_valid expected %0d actual %0d", $time, e.ov, out_valid);
					failed = 1;
				end
				if (out_value !== e.val) begin
					$display("%0t: out_value expected %0d actual %0d", $time,
						$signed(e.val), out_value);
					failed = 1;
				end
				if (fault !== e.flt) begin
					$display("%0t: fault expected %0d actual %0d", $time, e.flt, fault);
					failed = 1;
				end
			end
		end
	end

	// drain, settle, report
	initial begin
		@(posedge clk);
		while (!gen_done || pending_items.size() != 0 || in_valid
				|| expected_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (!failed && expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
design/pl0_pkg.sv
design/pl0_ram.sv
design/pl0_div.sv
design/pl0_stack_machine.sv
tb/pl0_stack_machine_tb.sv
